### rtl/core/bfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants of the Bernoulli function pair block.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int unsigned VW = 24;   // potential sample width
  localparam int unsigned RW = 23;   // result width, unsigned Q7.16
  localparam int unsigned AW = 23;   // magnitude of the clamped difference

  localparam logic [47:0] LN2_Q48    = 48'hB17217F7D1CF;
  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [RW-1:0] ONE_Q16  = 23'd65536;
  localparam logic [24:0] DIFF_LIMIT = 25'd4194304;
  localparam logic [4:0] SERIES_TERMS = 5'd20;

  // One classified request handed from the front end to the evaluator.
  typedef struct packed {
    logic [AW-1:0] mag;
    logic          neg;
    logic          zero;
    logic          sat;
    logic          last;
  } bfp_item_t;

endpackage

### rtl/core/bernoulli_function_pair_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bernoulli_function_pair_top
// Bernoulli function pair B(d), B(-d) of neighbor potential differences.
// ----------------------------------------------------------------------------
// Usage: samples enter on the s_axis channel, with tlast marking the final
// sample of a vector and tuser marking the first one. Every sample that has
// a predecessor in its vector yields one result on m_axis: B(d) and B(-d)
// in tdata, the clamp flag in tuser and the end-of-vector mark in tlast.
// A zero difference skips the arithmetic and goes straight to the output
// register. Any other difference passes through the ln2 reduction, 20
// series terms (each a multiply built from 32x32 partial products and a
// nibble division by the term index) and a bit-serial final division;
// this single shared evaluator works on one nonzero request at a time.
// A two-entry queue lets the front end take samples while the evaluator
// is busy; samples that make no result are taken while the queue has
// room. Reset clears the stored previous sample and the queue. When
// the receiver stalls, the result waits in the output register, the
// evaluator finishes the next request and then holds it until taken.
// ----------------------------------------------------------------------------
module bernoulli_function_pair_top import bfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] v_sample
  input  logic        s_axis_tuser,   // [0] first_sample
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [22:0] b_forward, [45:23] b_backward
  output logic        m_axis_tuser,   // [0] diff_saturated
  output logic        m_axis_tlast    // last_result
);

  logic          push, full, pop, avail;
  bfp_item_t     f_item, q_item;
  logic [RW-1:0] fwd, bwd;

  bfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .v_sample_i (s_axis_tdata),
    .first_i    (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .push_o     (push),
    .item_o     (f_item),
    .full_i     (full)
  );

  bfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (q_item)
  );

  bfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .b_forward_o  (fwd),
    .b_backward_o (bwd),
    .sat_o        (m_axis_tuser),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, bwd, fwd};

endmodule

### rtl/core/bfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_front
// Accepts potential samples, forms and clamps the neighbor difference.
// ----------------------------------------------------------------------------
module bfp_front import bfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [VW-1:0] v_sample_i,
  input  logic          first_i,
  input  logic          last_i,
  output logic          push_o,
  output bfp_item_t     item_o,
  input  logic          full_i
);

  logic [VW-1:0] prev_q, prev_d;
  logic          have_q, have_d;
  logic [24:0]   diff;
  logic [24:0]   clamped;
  logic          accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    diff = {v_sample_i[VW-1], v_sample_i} - {prev_q[VW-1], prev_q};
    item_o.sat = 1'b0;
    clamped = diff;
    if (!diff[24] && diff > DIFF_LIMIT) begin
      clamped = DIFF_LIMIT;
      item_o.sat = 1'b1;
    end else if (diff[24] && diff < (25'd0 - DIFF_LIMIT)) begin
      clamped = 25'd0 - DIFF_LIMIT;
      item_o.sat = 1'b1;
    end
    item_o.neg  = clamped[24];
    item_o.zero = (clamped == 25'd0);
    item_o.mag  = clamped[24] ? AW'(25'd0 - clamped) : clamped[AW-1:0];
    item_o.last = last_i;
  end

  assign push_o = accept && !first_i && have_q;

  always_comb begin
    prev_d = prev_q;
    have_d = have_q;
    if (accept) begin
      prev_d = v_sample_i;
      have_d = !last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      have_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      have_q <= have_d;
    end
  end

endmodule

### rtl/core/bfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_queue
// Two-entry queue between the front end and the evaluator.
// ----------------------------------------------------------------------------
module bfp_queue import bfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bfp_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      avail_o,
  output bfp_item_t item_o
);

  bfp_item_t  slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = !wptr_q;
      cnt_d  = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rptr_d = !rptr_q;
      cnt_d  = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### rtl/core/bfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_back
// Sequential evaluator: range reduction, exp series, final division, and
// the output register.
// ----------------------------------------------------------------------------
module bfp_back import bfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  bfp_item_t     item_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [RW-1:0] b_forward_o,
  output logic [RW-1:0] b_backward_o,
  output logic          sat_o,
  output logic          last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NDIV = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_KDIV = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_QDIV = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    st_q, st_d;
  bfp_item_t     it_q, it_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [54:0]   nrem_q, nrem_d;
  logic [6:0]    n_q, n_d;
  logic [59:0]   red_q, red_d;
  logic [60:0]   term_q, term_d;
  logic [63:0]   sum_q, sum_d;
  logic [4:0]    k_q, k_d;
  logic [1:0]    pp_q, pp_d;
  logic [121:0]  acc_q, acc_d;
  logic [59:0]   prod_q, prod_d;
  logic [55:0]   kquo_q, kquo_d;
  logic [4:0]    krem_q, krem_d;
  logic [62:0]   dvd_q, dvd_d;
  logic [43:0]   den_q, den_d;
  logic [43:0]   qrem_q, qrem_d;
  logic [61:0]   quo_q, quo_d;
  logic [RW-1:0] fwd_q, fwd_d, bwd_q, bwd_d;
  logic          ov_q, ov_d;
  logic [RW-1:0] of_q, of_d, ob_q, ob_d;
  logic          os_q, os_d, ol_q, ol_d;

  // Shared datapath intermediates.
  logic [54:0]   nsub;
  logic [31:0]   mx, my;
  logic [63:0]   pprod;
  logic [121:0]  pshift;
  logic [5:0]    kr;
  logic [3:0]    kq;
  logic [59:0]   knew;
  logic [63:0]   expv, dfull;
  logic [43:0]   dent;
  logic [44:0]   qr;
  logic          qbit;
  logic [62:0]   lg_val;
  logic [62:0]   sm_val;
  logic [62:0]   amag;

  assign out_valid_o  = ov_q;
  assign b_forward_o  = of_q;
  assign b_backward_o = ob_q;
  assign sat_o        = os_q;
  assign last_o       = ol_q;

  always_comb begin
    st_d = st_q; it_d = it_q; cnt_d = cnt_q; nrem_d = nrem_q; n_d = n_q;
    red_d = red_q; term_d = term_q; sum_d = sum_q; k_d = k_q; pp_d = pp_q;
    acc_d = acc_q; prod_d = prod_q; kquo_d = kquo_q; krem_d = krem_q;
    dvd_d = dvd_q; den_d = den_q; qrem_d = qrem_q; quo_d = quo_q;
    fwd_d = fwd_q; bwd_d = bwd_q;
    ov_d = ov_q; of_d = of_q; ob_d = ob_q; os_d = os_q; ol_d = ol_q;
    pop_o = 1'b0;

    nsub = 55'({7'd0, LN2_Q48} << cnt_q[2:0]);

    case (pp_q)
      2'd0:    begin mx = term_q[31:0];         my = red_q[31:0];         end
      2'd1:    begin mx = term_q[31:0];         my = {4'd0, red_q[59:32]}; end
      2'd2:    begin mx = {3'd0, term_q[60:32]}; my = red_q[31:0];         end
      default: begin mx = {3'd0, term_q[60:32]}; my = {4'd0, red_q[59:32]}; end
    endcase
    pprod = mx * my;
    case (pp_q)
      2'd0:    pshift = {58'd0, pprod};
      2'd3:    pshift = {pprod[57:0], 64'd0};
      default: pshift = {26'd0, pprod, 32'd0};
    endcase

    // Four restoring steps of the division by the term index.
    kr = {1'b0, krem_q};
    kq = '0;
    for (int i = 3; i >= 0; i--) begin
      kr = {kr[4:0], prod_q[56+i]};
      if (kr >= {1'b0, k_q}) begin
        kr = kr - {1'b0, k_q};
        kq[i] = 1'b1;
      end
    end
    knew = {kquo_q, kq};

    expv  = (n_q < 7'd64) ? (sum_q >> n_q[5:0]) : 64'd0;
    dfull = ONE_Q60 - expv;
    dent  = (dfull[63:20] == 44'd0) ? 44'd1 : dfull[63:20];

    qr   = {qrem_q, dvd_q[62]};
    qbit = (qr >= {1'b0, den_q});
    if (qbit) begin
      qr = qr - {1'b0, den_q};
    end
    lg_val = {quo_q, qbit};
    amag   = {40'd0, it_q.mag};
    sm_val = (lg_val >= amag) ? lg_val - amag : 63'd0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          it_d  = item_i;
          if (item_i.zero) begin
            fwd_d = ONE_Q16;
            bwd_d = ONE_Q16;
            st_d  = S_OUT;
          end else begin
            nrem_d = {item_i.mag, 32'd0};
            n_d    = '0;
            cnt_d  = 7'd6;
            st_d   = S_NDIV;
          end
        end
      end
      S_NDIV: begin
        if (nrem_q >= nsub) begin
          nrem_d = nrem_q - nsub;
          n_d[cnt_q[2:0]] = 1'b1;
        end
        if (cnt_q == 7'd0) begin
          red_d  = {nrem_d[47:0], 12'd0};
          term_d = ONE_Q60[60:0];
          sum_d  = ONE_Q60;
          k_d    = 5'd1;
          pp_d   = 2'd0;
          acc_d  = '0;
          st_d   = S_MUL;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_MUL: begin
        acc_d = acc_q + pshift;
        pp_d  = pp_q + 2'd1;
        if (pp_q == 2'd3) begin
          prod_d = acc_d[119:60];
          kquo_d = '0;
          krem_d = '0;
          cnt_d  = 7'd14;
          st_d   = S_KDIV;
        end
      end
      S_KDIV: begin
        prod_d = {prod_q[55:0], 4'd0};
        kquo_d = knew[55:0];
        krem_d = kr[4:0];
        if (cnt_q == 7'd0) begin
          term_d = {1'b0, knew};
          sum_d  = k_q[0] ? sum_q - {4'd0, knew} : sum_q + {4'd0, knew};
          if (k_q == SERIES_TERMS) begin
            st_d = S_FIN;
          end else begin
            k_d   = k_q + 5'd1;
            acc_d = '0;
            pp_d  = 2'd0;
            st_d  = S_MUL;
          end
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_FIN: begin
        den_d  = dent;
        dvd_d  = {it_q.mag, 40'd0} + {20'd0, dent[43:1]};
        qrem_d = '0;
        quo_d  = '0;
        cnt_d  = 7'd62;
        st_d   = S_QDIV;
      end
      S_QDIV: begin
        dvd_d  = {dvd_q[61:0], 1'b0};
        qrem_d = qr[43:0];
        quo_d  = lg_val[61:0];
        if (cnt_q == 7'd0) begin
          if (it_q.neg) begin
            fwd_d = lg_val[RW-1:0];
            bwd_d = sm_val[RW-1:0];
          end else begin
            fwd_d = sm_val[RW-1:0];
            bwd_d = lg_val[RW-1:0];
          end
          st_d = S_OUT;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_OUT: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          of_d = fwd_q;
          ob_d = bwd_q;
          os_d = it_q.sat;
          ol_d = it_q.last;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; cnt_q <= cnt_d; nrem_q <= nrem_d; n_q <= n_d;
    red_q <= red_d; term_q <= term_d; sum_q <= sum_d; k_q <= k_d;
    pp_q <= pp_d; acc_q <= acc_d; prod_q <= prod_d; kquo_q <= kquo_d;
    krem_q <= krem_d; dvd_q <= dvd_d; den_q <= den_d; qrem_q <= qrem_d;
    quo_q <= quo_d; fwd_q <= fwd_d; bwd_q <= bwd_d;
    of_q <= of_d; ob_q <= ob_d; os_q <= os_d; ol_q <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

endmodule
